### rtl/core/bfer_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfer_pkg
// Shared types and constants for the Bellman-Ford relaxation engine.
// ----------------------------------------------------------------------------
package bfer_pkg;

    localparam int VERTEX_BITS = 16;
    localparam int MAX_VERTICES = 1 << VERTEX_BITS;
    localparam int DIST_BITS = 32;
    localparam int RC_BITS = 17;
    localparam int CMD_BITS = 2;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [DIST_BITS-1:0] INF_DIST = DIST_BITS'(24'hffffff);
    localparam logic [DIST_BITS-1:0] NEG_INF_DIST = DIST_BITS'(0) - INF_DIST;
    localparam logic [RC_BITS-1:0] RC_MAX = {RC_BITS{1'b1}};
    localparam logic [RC_BITS-1:0] VCOUNT_RESET = RC_BITS'(MAX_VERTICES);

    typedef enum logic [CMD_BITS-1:0] {
        CMD_RELAX     = 2'd0,
        CMD_ROUND_END = 2'd1,
        CMD_READ      = 2'd2,
        CMD_INIT      = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SOURCE = 1'b0,
        CFG_VCOUNT = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_EXEC
    } state_t;

    // write port of the distance / mark store
    typedef struct packed {
        logic                   dist_we;
        logic                   mark_we;
        logic [VERTEX_BITS-1:0] addr;
        logic [DIST_BITS-1:0]   dist_data;
        logic                   mark;
    } store_wr_t;

endpackage : bfer_pkg
`default_nettype wire

### rtl/core/bfer_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfer_store
// Distance memory (two read ports, one write) and visited-mark memory.
// Read data is registered.
// ----------------------------------------------------------------------------
module bfer_store (
    input  wire logic                             aclk,
    input  wire logic                             rd_en,
    input  wire logic [bfer_pkg::VERTEX_BITS-1:0] rd_from_addr,
    input  wire logic [bfer_pkg::VERTEX_BITS-1:0] rd_to_addr,
    input  wire bfer_pkg::store_wr_t              wr,
    output logic      [bfer_pkg::DIST_BITS-1:0]   rd_from_dist,
    output logic      [bfer_pkg::DIST_BITS-1:0]   rd_to_dist,
    output logic                                  rd_to_mark
);
    import bfer_pkg::*;

    logic [DIST_BITS-1:0] dist_mem [MAX_VERTICES];
    logic                 mark_mem [MAX_VERTICES];

    always_ff @(posedge aclk) begin
        if (wr.dist_we) begin
            dist_mem[wr.addr] <= wr.dist_data;
        end
        if (wr.mark_we) begin
            mark_mem[wr.addr] <= wr.mark;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_from_dist <= dist_mem[rd_from_addr];
            rd_to_dist   <= dist_mem[rd_to_addr];
            rd_to_mark   <= mark_mem[rd_to_addr];
        end
    end

endmodule : bfer_store
`default_nettype wire

### rtl/core/bellman_ford_edge_relaxation.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bellman_ford_edge_relaxation
// Frontier Bellman-Ford relaxation engine: relax, end of round, read, init.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+------------------------------------
//  s_      | in  | s_valid / s_ready     | cmd, from_vertex, to_vertex,
//          |     |                       | edge_weight
//  m_      | out | m_valid / m_ready     | activated, activated_vertex,
//          |     |                       | distance, frontier_empty,
//          |     |                       | negative_cycle
//  cfg_    | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  On accept an item issues the memory reads; in the execute state it does the
//  compare/write-back and loads the result register.
//  Init and end-of-round also sweep all 65536 store entries, one entry a cycle.
//  After reset a sweep clears the visited marks; s_ready is low.
//  While a result waits in the output register the next item is still taken;
//  it holds in the execute cycle until the output register frees up.
// ----------------------------------------------------------------------------
module bellman_ford_edge_relaxation (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input items
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [bfer_pkg::CMD_BITS-1:0]     s_cmd,
    input  wire logic [bfer_pkg::VERTEX_BITS-1:0]  s_from_vertex,
    input  wire logic [bfer_pkg::VERTEX_BITS-1:0]  s_to_vertex,
    input  wire logic signed [bfer_pkg::DIST_BITS-1:0] s_edge_weight,
    // result items
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_activated,
    output logic      [bfer_pkg::VERTEX_BITS-1:0]  m_activated_vertex,
    output logic signed [bfer_pkg::DIST_BITS-1:0]  m_distance,
    output logic                                   m_frontier_empty,
    output logic                                   m_negative_cycle,
    // configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bfer_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [bfer_pkg::RC_BITS-1:0]      cfg_data
);
    import bfer_pkg::*;

    // ---------------------------------------------------------------- state
    state_t                 state_reg, state_next;

    // config registers
    logic [VERTEX_BITS-1:0] source_vertex_reg;
    logic [RC_BITS-1:0]     vertex_count_reg;

    // round bookkeeping
    logic [RC_BITS-1:0]     round_count_reg, round_count_next;
    logic                   any_activated_reg, any_activated_next;
    logic                   cycle_found_reg, cycle_found_next;

    // captured item
    cmd_t                   cmd_reg;
    logic [VERTEX_BITS-1:0] to_vertex_reg;
    logic [DIST_BITS-1:0]   weight_reg;

    // sweep control
    logic [VERTEX_BITS-1:0] sweep_addr_reg;
    logic                   sweep_dist_reg;   // sweep also writes distances
    logic                   sweep_init_reg;   // source entry gets zero
    logic [VERTEX_BITS-1:0] sweep_src_reg;
    logic [DIST_BITS-1:0]   sweep_val_reg;
    logic                   sweep_last;

    // output register
    logic                   m_valid_reg;
    logic                   m_activated_reg;
    logic [VERTEX_BITS-1:0] m_activated_vertex_reg;
    logic [DIST_BITS-1:0]   m_distance_reg;
    logic                   m_frontier_empty_reg;
    logic                   m_negative_cycle_reg;

    // store interface
    logic                   s_accept;
    logic                   out_free;
    logic                   exec_fire;
    store_wr_t              wr;
    logic [DIST_BITS-1:0]   rd_from_dist;
    logic [DIST_BITS-1:0]   rd_to_dist;
    logic                   rd_to_mark;

    // relax datapath
    logic [DIST_BITS-1:0]   new_dist;
    logic                   improves;
    logic                   relax_write;
    logic                   relax_act;

    // round-end datapath
    logic [RC_BITS-1:0]     rc_inc;
    logic                   fill_neg;

    bfer_store u_store (
        .aclk         (aclk),
        .rd_en        (s_accept),
        .rd_from_addr (s_from_vertex),
        .rd_to_addr   (s_to_vertex),
        .wr           (wr),
        .rd_from_dist (rd_from_dist),
        .rd_to_dist   (rd_to_dist),
        .rd_to_mark   (rd_to_mark)
    );

    // ------------------------------------------------------------ datapath
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign exec_fire = (state_reg == ST_EXEC) && out_free;
    assign sweep_last = &sweep_addr_reg;

    // 32-bit wrapping sum, signed compare against stored destination
    assign new_dist    = rd_from_dist + weight_reg;
    assign improves    = $signed(new_dist) < $signed(rd_to_dist);
    assign relax_write = !cycle_found_reg && improves;
    assign relax_act   = relax_write && !rd_to_mark;

    assign rc_inc   = (round_count_reg == RC_MAX) ? round_count_reg
                                                  : round_count_reg + RC_BITS'(1);
    assign fill_neg = any_activated_reg && (rc_inc == vertex_count_reg);

    // ---------------------------------------------------------- next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SWEEP: begin
                if (sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    if (cmd_reg == CMD_INIT || cmd_reg == CMD_ROUND_END) begin
                        state_next = ST_SWEEP;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------- store writes, bookkeeping
    always_comb begin
        wr                 = '0;
        round_count_next   = round_count_reg;
        any_activated_next = any_activated_reg;
        cycle_found_next   = cycle_found_reg;
        unique case (state_reg)
            ST_SWEEP: begin
                wr.mark_we   = 1'b1;
                wr.mark      = 1'b0;
                wr.dist_we   = sweep_dist_reg;
                wr.addr      = sweep_addr_reg;
                wr.dist_data = (sweep_init_reg && sweep_addr_reg == sweep_src_reg)
                               ? '0 : sweep_val_reg;
            end
            ST_EXEC: begin
                if (out_free) begin
                    unique case (cmd_reg)
                        CMD_RELAX: begin
                            wr.dist_we   = relax_write;
                            wr.mark_we   = relax_act;
                            wr.addr      = to_vertex_reg;
                            wr.dist_data = new_dist;
                            wr.mark      = 1'b1;
                            if (relax_act) begin
                                any_activated_next = 1'b1;
                            end
                        end
                        CMD_ROUND_END: begin
                            round_count_next   = rc_inc;
                            any_activated_next = 1'b0;
                            if (fill_neg) begin
                                cycle_found_next = 1'b1;
                            end
                        end
                        CMD_READ: begin
                        end
                        CMD_INIT: begin
                            round_count_next   = '0;
                            any_activated_next = 1'b0;
                            cycle_found_next   = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    // ----------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_SWEEP;
            sweep_addr_reg    <= '0;
            sweep_dist_reg    <= 1'b0;
            sweep_init_reg    <= 1'b0;
            source_vertex_reg <= '0;
            vertex_count_reg  <= VCOUNT_RESET;
            round_count_reg   <= '0;
            any_activated_reg <= 1'b0;
            cycle_found_reg   <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg         <= state_next;
            round_count_reg   <= round_count_next;
            any_activated_reg <= any_activated_next;
            cycle_found_reg   <= cycle_found_next;

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_SOURCE: source_vertex_reg <= cfg_data[VERTEX_BITS-1:0];
                    CFG_VCOUNT: vertex_count_reg  <= cfg_data;
                    default:    source_vertex_reg <= source_vertex_reg;
                endcase
            end

            // sweep sequencing
            if (state_reg == ST_SWEEP) begin
                sweep_addr_reg <= sweep_addr_reg + VERTEX_BITS'(1);
            end else if (exec_fire) begin
                sweep_addr_reg <= '0;
                sweep_init_reg <= (cmd_reg == CMD_INIT);
                sweep_dist_reg <= (cmd_reg == CMD_INIT) || fill_neg;
            end

            if (exec_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg       <= cmd_t'(s_cmd);
            to_vertex_reg <= s_to_vertex;
            weight_reg    <= s_edge_weight;
        end
        if (exec_fire) begin
            sweep_src_reg <= source_vertex_reg;
            sweep_val_reg <= (cmd_reg == CMD_INIT) ? INF_DIST : NEG_INF_DIST;

            m_activated_reg        <= (cmd_reg == CMD_RELAX) && relax_act;
            m_activated_vertex_reg <= ((cmd_reg == CMD_RELAX) && relax_act)
                                      ? to_vertex_reg : '0;
            m_distance_reg         <= (cmd_reg == CMD_READ) ? rd_to_dist : '0;
            m_frontier_empty_reg   <= (cmd_reg == CMD_ROUND_END) && !any_activated_reg;
            m_negative_cycle_reg   <= cycle_found_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_activated        = m_activated_reg;
    assign m_activated_vertex = m_activated_vertex_reg;
    assign m_distance         = m_distance_reg;
    assign m_frontier_empty   = m_frontier_empty_reg;
    assign m_negative_cycle   = m_negative_cycle_reg;

    // ---------------------------------------------------------- assertions
    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_EXEC))
        else $error("accepted item did not enter execute");

    a_sweep_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP && sweep_last) |=> (state_reg == ST_IDLE))
        else $error("sweep did not end after last entry");

    a_no_write_after_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC && cmd_reg == CMD_RELAX && cycle_found_reg)
        |-> !wr.dist_we)
        else $error("relax wrote a distance after a negative cycle");

    a_act_implies_any: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_activated_reg) |-> any_activated_reg)
        else $error("activation reported but round flag clear");

    a_exec_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC && !out_free) |=> (state_reg == ST_EXEC))
        else $error("execute left while output register was full");

endmodule : bellman_ford_edge_relaxation
`default_nettype wire
